// ===== rtl/blake2s_compression_unit_defines.svh =====
// Assertion macros for the BLAKE2s compression unit checker.
// No dependencies; included by the checker file only.
`ifndef BLAKE2S_COMPRESSION_UNIT_DEFINES_SVH
`define BLAKE2S_COMPRESSION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high
`define B2S_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high
`define B2S_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/b2s_pkg.sv =====
// Shared types, constants and helper functions for the BLAKE2s core.
// No dependencies; imported by every design module of the block but the checker.
package b2s_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_FEED,
    ST_OUT
  } state_t;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_WORD  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DIGEST_LEN = 1'b0;
  localparam logic CFG_KEY_SIZE   = 1'b1;

  localparam logic [5:0] DIGEST_LEN_RST = 6'd32;
  localparam logic [5:0] KEY_SIZE_RST   = 6'd0;

  // Fanout 1, depth 1 in the parameter word
  localparam logic [31:0] PARAM_FIXED = 32'h0101_0000;

  localparam logic [6:0] BLOCK_BYTES_MAX = 7'd64;
  localparam logic [3:0] LAST_WORD_POS   = 4'd15;
  localparam logic [3:0] LAST_ROUND      = 4'd9;
  localparam logic [2:0] LAST_G          = 3'd7;
  localparam logic [2:0] LAST_COL_G      = 3'd3;
  localparam logic [2:0] LAST_DIGEST     = 3'd7;

  // G rotation distances, as right rotates
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // Message schedule lookup; rounds past the last read as round 0
  function automatic logic [3:0] sigma(input logic [3:0] round, input logic [3:0] pos);
    logic [3:0] idx;
    idx = SIGMA[0][pos];
    if (round <= LAST_ROUND) begin
      idx = SIGMA[round][pos];
    end
    return idx;
  endfunction

  // Right rotate by a constant distance
  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/blake2s_compression_unit.sv =====
// BLAKE2s-256 compression unit: start beats, message word beats and digest beats.
// Depends on b2s_pkg, b2s_g_half and b2s_msg_buf.
//
// A start beat or any of the first fifteen words of a block is taken with no
// stall. The sixteenth word starts a compression, and the input stays stalled
// while the working vector is loaded, ten rounds run as 16 half-G steps each
// on a single shared half-G unit, and the feed-forward is done. After a block
// marked final, the eight digest words follow as beats, word 0 first, one per
// cycle while the output is not stalled; input stays stalled until the last one
// has gone. The config port may be written only while the block is idle.
module blake2s_compression_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] msg_word,
  input  logic        final_block,
  input  logic [6:0]  block_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        digest_last
);
  import b2s_pkg::*;

  state_t      state, state_next;
  logic [5:0]  digest_len;
  logic [5:0]  key_size;
  logic [31:0] chain [8];
  logic [63:0] byte_count;
  logic [3:0]  position;
  logic        last_flag;
  logic [31:0] v [16];
  logic [31:0] v_mix [16];
  logic [3:0]  round, round_next;
  logic [2:0]  gidx, gidx_next;
  logic        half, half_next;
  logic [2:0]  out_idx, out_idx_next;
  logic        in_beat;
  logic        out_beat;
  logic        block_end;
  logic [6:0]  bytes_sat;
  logic [31:0] msg_rd;
  logic [3:0]  msg_rd_addr;
  logic [31:0] ga, gb, gc, gd;

  assign in_stall    = (state != ST_IDLE);
  assign in_beat     = in_valid && !in_stall;
  assign out_valid   = (state == ST_OUT);
  assign out_beat    = out_valid && !out_stall;
  assign digest_word = chain[out_idx];
  assign digest_last = (out_idx == LAST_DIGEST);
  assign block_end   = in_beat && (action == ACT_WORD) && (position == LAST_WORD_POS);
  assign bytes_sat   = (block_bytes > BLOCK_BYTES_MAX) ? BLOCK_BYTES_MAX : block_bytes;

  // Row rotate amount after a full G; folds in (un)diagonalisation
  function automatic logic [1:0] rot_amt(input logic [2:0] g, input logic [1:0] row);
    logic [1:0] amt;
    amt = 2'd1;
    if (g == LAST_COL_G) begin
      amt = 2'd1 + row;
    end else if (g == LAST_G) begin
      amt = 2'd1 - row;
    end
    return amt;
  endfunction

  // Message store, read address follows the next step's schedule slot
  assign msg_rd_addr = sigma(round_next, {gidx_next, half_next});

  b2s_msg_buf u_msg (
    .clk     (clk),
    .wr_en   (in_beat && (action == ACT_WORD)),
    .wr_addr (position),
    .wr_data (msg_word),
    .rd_addr (msg_rd_addr),
    .rd_data (msg_rd)
  );

  // Shared half-G unit always works on column 0 of the working vector
  b2s_g_half u_g (
    .second (half),
    .a_in   (v[0]),
    .b_in   (v[4]),
    .c_in   (v[8]),
    .d_in   (v[12]),
    .m_in   (msg_rd),
    .a_out  (ga),
    .b_out  (gb),
    .c_out  (gc),
    .d_out  (gd)
  );

  // Column 0 replaced by the G results
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      v_mix[i] = v[i];
    end
    v_mix[0]  = ga;
    v_mix[4]  = gb;
    v_mix[8]  = gc;
    v_mix[12] = gd;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_len <= DIGEST_LEN_RST;
      key_size   <= KEY_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIGEST_LEN: digest_len <= cfg_data;
        CFG_KEY_SIZE:   key_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain value, byte counter, word position and final flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= IV_WORDS[i];
      end
      byte_count <= '0;
      position   <= '0;
      last_flag  <= 1'b0;
    end else if (in_beat && (action == ACT_START)) begin
      // word 0 carries the parameter word
      for (int i = 1; i < 8; i++) begin
        chain[i] <= IV_WORDS[i];
      end
      chain[0]   <= IV_WORDS[0] ^ PARAM_FIXED ^ {16'd0, 2'd0, key_size, 2'd0, digest_len};
      byte_count <= '0;
      position   <= '0;
    end else if (in_beat) begin
      position <= position + 4'd1;
      if (block_end) begin
        byte_count <= byte_count + {57'd0, bytes_sat};
        last_flag  <= final_block;
      end
    end else if (state == ST_FEED) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] ^ v[i] ^ v[i + 8];
      end
    end
  end

  // Working vector: load, then one half-G step per cycle
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
      for (int i = 0; i < 4; i++) begin
        v[i + 8] <= IV_WORDS[i];
      end
      v[12] <= IV_WORDS[4] ^ byte_count[31:0];
      v[13] <= IV_WORDS[5] ^ byte_count[63:32];
      v[14] <= IV_WORDS[6] ^ {32{last_flag}};
      v[15] <= IV_WORDS[7];
    end else if (state == ST_RUN) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          if (half) begin
            v[4 * r + c] <= v_mix[4 * r + 2'(2'(c) + rot_amt(gidx, 2'(r)))];
          end else begin
            v[4 * r + c] <= v_mix[4 * r + c];
          end
        end
      end
    end
  end

  // Sequencer state and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      round   <= '0;
      gidx    <= '0;
      half    <= 1'b0;
      out_idx <= '0;
    end else begin
      state   <= state_next;
      round   <= round_next;
      gidx    <= gidx_next;
      half    <= half_next;
      out_idx <= out_idx_next;
    end
  end

  // Next state and counter steps
  always_comb begin
    state_next   = state;
    round_next   = round;
    gidx_next    = gidx;
    half_next    = half;
    out_idx_next = out_idx;
    case (state)
      ST_IDLE: begin
        if (block_end) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        state_next = ST_RUN;
        round_next = '0;
        gidx_next  = '0;
        half_next  = 1'b0;
      end
      ST_RUN: begin
        half_next = !half;
        if (half) begin
          gidx_next = gidx + 3'd1;
          if (gidx == LAST_G) begin
            round_next = round + 4'd1;
            if (round == LAST_ROUND) begin
              state_next = ST_FEED;
            end
          end
        end
      end
      ST_FEED: begin
        out_idx_next = '0;
        state_next   = last_flag ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_beat) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == LAST_DIGEST) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/b2s_g_half.sv =====
// Half of the BLAKE2s G function: one add/xor/rotate pass on a column.
// Depends on b2s_pkg for the rotation helper and distances.
module b2s_g_half (
  input  logic        second,
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  input  logic [31:0] c_in,
  input  logic [31:0] d_in,
  input  logic [31:0] m_in,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);
  import b2s_pkg::*;

  logic [31:0] d_mix;
  logic [31:0] b_mix;

  // First half rotates by 16/12, second half by 8/7
  always_comb begin
    a_out = a_in + b_in + m_in;
    d_mix = d_in ^ a_out;
    d_out = second ? rotr(d_mix, ROT_C) : rotr(d_mix, ROT_A);
    c_out = c_in + d_out;
    b_mix = b_in ^ c_out;
    b_out = second ? rotr(b_mix, ROT_D) : rotr(b_mix, ROT_B);
  end

endmodule

// ===== rtl/b2s_msg_buf.sv =====
// Sixteen-word message block store, one write and one registered read port.
// Depends on b2s_pkg only by convention; no reset, entries valid once written.
module b2s_msg_buf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);
  import b2s_pkg::*;

  logic [31:0] mem [16];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, address presented the cycle before
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/b2s_checker.sv =====
// Port-level checks for the BLAKE2s compression unit, bound to the top level.
// Depends on blake2s_compression_unit_defines.svh for the assertion macros.
`include "blake2s_compression_unit_defines.svh"

module b2s_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic        digest_last
);

  // A stalled digest beat holds
  `B2S_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(digest_last), "digest beat changed while stalled")

  // No message beat is taken while a digest is being delivered
  `B2S_CHK_NOW(a_busy_out, out_valid, in_stall, "input ready during digest output")

  // Digest words come back to back, none after the last
  `B2S_CHK_NEXT(a_dig_cont, out_valid && !out_stall && !digest_last, out_valid, "digest burst broken")
  `B2S_CHK_NEXT(a_dig_end, out_valid && !out_stall && digest_last, !out_valid, "beat after last digest word")

endmodule

bind blake2s_compression_unit b2s_checker u_b2s_checker (.*);

// ===== dv/blake2s_digest_checker.sv =====
// Digest checker for the BLAKE2s compression unit: follows the config and input
// beats, predicts every digest beat and compares the beats leaving the block.
// Depends on b2s_pkg for the action and register codes only.
module blake2s_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [31:0] msg_word,
  input  logic        final_block,
  input  logic [6:0]  block_bytes,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic        digest_last,
  output int          fail_count,
  output int          pending
);
  import b2s_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  localparam int MAX_REPORTS = 10;

  localparam logic [31:0] INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message word order per round, one nibble per position, position 0 leftmost
  localparam logic [63:0] MSG_ORDER [10] = '{
    64'h0123456789abcdef, 64'hea489fd61c02b753, 64'hb8c052fdae367194,
    64'h7931dcbe265a40f8, 64'h905724afe1bc683d, 64'h2c6a0b834d75fe19,
    64'hc51fed4a0763928b, 64'hdb7ec13950f4862a, 64'h6fe9b308c2d714a5,
    64'ha2847615fb9e3cd0
  };

  logic [5:0]   digest_len_reg;
  logic [5:0]   key_size_reg;
  logic [31:0]  chain [8];
  logic [63:0]  byte_count;
  logic [31:0]  blk_words [16];
  logic [3:0]   word_pos;
  logic [31:0]  work_v [16];
  digest_beat_t digest_q [$];
  int           errors = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

  // One G step on the working vector
  function automatic void g_mix(input int a, input int b, input int c, input int d,
                                input logic [31:0] x, input logic [31:0] y);
    work_v[a] = work_v[a] + work_v[b] + x;
    work_v[d] = ror32(work_v[d] ^ work_v[a], 16);
    work_v[c] = work_v[c] + work_v[d];
    work_v[b] = ror32(work_v[b] ^ work_v[c], 12);
    work_v[a] = work_v[a] + work_v[b] + y;
    work_v[d] = ror32(work_v[d] ^ work_v[a], 8);
    work_v[c] = work_v[c] + work_v[d];
    work_v[b] = ror32(work_v[b] ^ work_v[c], 7);
  endfunction

  function automatic logic [31:0] sched(input int r, input int i);
    logic [63:0] row;
    row = MSG_ORDER[r];
    return blk_words[row[(15 - i) * 4 +: 4]];
  endfunction

  // Ten rounds over the buffered block, then feed-forward into the chain
  function automatic void blake2s_compress(input logic last_blk);
    int i;
    int r;
    for (i = 0; i < 8; i++) begin
      work_v[i]     = chain[i];
      work_v[i + 8] = INIT_CHAIN[i];
    end
    work_v[12] ^= byte_count[31:0];
    work_v[13] ^= byte_count[63:32];
    if (last_blk) begin
      work_v[14] = ~work_v[14];
    end
    for (r = 0; r < 10; r++) begin
      g_mix(0, 4, 8, 12, sched(r, 0), sched(r, 1));
      g_mix(1, 5, 9, 13, sched(r, 2), sched(r, 3));
      g_mix(2, 6, 10, 14, sched(r, 4), sched(r, 5));
      g_mix(3, 7, 11, 15, sched(r, 6), sched(r, 7));
      g_mix(0, 5, 10, 15, sched(r, 8), sched(r, 9));
      g_mix(1, 6, 11, 12, sched(r, 10), sched(r, 11));
      g_mix(2, 7, 8, 13, sched(r, 12), sched(r, 13));
      g_mix(3, 4, 9, 14, sched(r, 14), sched(r, 15));
    end
    for (i = 0; i < 8; i++) begin
      chain[i] ^= work_v[i] ^ work_v[i + 8];
    end
  endfunction

  // Update the hash state for one input beat; queue the digest after a final block
  function automatic void absorb_beat(input logic act, input logic [31:0] word,
                                      input logic fin, input logic [6:0] nbytes);
    int           i;
    logic [6:0]   counted;
    digest_beat_t beat;
    if (act == ACT_START) begin
      for (i = 0; i < 8; i++) begin
        chain[i] = INIT_CHAIN[i];
      end
      chain[0] ^= {16'h0101, 2'b00, key_size_reg, 2'b00, digest_len_reg};
      byte_count = '0;
      word_pos   = '0;
    end else begin
      blk_words[word_pos] = word;
      if (word_pos != 4'd15) begin
        word_pos = word_pos + 4'd1;
      end else begin
        word_pos = '0;
        counted  = (nbytes > 7'd64) ? 7'd64 : nbytes;
        byte_count = byte_count + {57'd0, counted};
        blake2s_compress(fin);
        if (fin) begin
          for (i = 0; i < 8; i++) begin
            beat.word = chain[i];
            beat.last = (i == 7);
            digest_q.push_back(beat);
          end
        end
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    digest_beat_t expected;
    int           i;
    if (rst) begin
      digest_len_reg = 6'd32;
      key_size_reg   = 6'd0;
      for (i = 0; i < 8; i++) begin
        chain[i] = INIT_CHAIN[i];
      end
      byte_count = '0;
      word_pos   = '0;
      digest_q.delete();
    end else begin
      // Outgoing digest beats against the oldest prediction
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("unexpected digest beat: word %h last %b", digest_word, digest_last);
          end
        end else begin
          expected = digest_q.pop_front();
          if (digest_word !== expected.word || digest_last !== expected.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("digest beat wrong: expected word %h last %b, got word %h last %b",
                       expected.word, expected.last, digest_word, digest_last);
            end
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_DIGEST_LEN) begin
          digest_len_reg = cfg_data;
        end else begin
          key_size_reg = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        absorb_beat(action, msg_word, final_block, block_bytes);
      end
    end
    fail_count <= errors;
    pending    <= digest_q.size();
  end

endmodule

// ===== dv/blake2s_compression_unit_tb.sv =====
// Testbench top for the BLAKE2s compression unit: clock, reset, config writes,
// message beats and digest-side stalls, with the verdict at the end.
// Depends on b2s_pkg, blake2s_compression_unit and blake2s_digest_checker.
module blake2s_compression_unit_tb;
  import b2s_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 200;   // longer than one compression
  localparam int ITEMS_PER_PHASE = 70;
  localparam int PHASES          = 6;
  localparam int RANDOM_CFG      = 4;     // phase with random register values

  // Idling per phase, modulo 4: none, sender, receiver, both
  localparam int SEND_IDLE [4]  = '{0, 46, 0, 8};
  localparam int RECV_STALL [4] = '{0, 0, 46, 8};

  // Register settings from phase 1 on; phase 0 runs on reset values
  localparam logic [5:0] OUT_SETS [PHASES] = '{6'd32, 6'd1, 6'd0, 6'h3f, 6'd32, 6'd32};
  localparam logic [5:0] KEY_SETS [PHASES] = '{6'd0, 6'd32, 6'd0, 6'h3f, 6'd0, 6'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_DIGEST_LEN;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = ACT_START;
  logic [31:0] msg_word = '0;
  logic        final_block = 1'b0;
  logic [6:0]  block_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  logic [5:0]  key_now = KEY_SIZE_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  blake2s_compression_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .msg_word    (msg_word),
    .final_block (final_block),
    .block_bytes (block_bytes),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .digest_last (digest_last)
  );

  blake2s_digest_checker u_digest_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .msg_word    (msg_word),
    .final_block (final_block),
    .block_bytes (block_bytes),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .digest_last (digest_last),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Digest-side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one beat, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_beat(input logic act, input logic [31:0] word, input logic fin,
                           input logic [6:0] nbytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    msg_word    <= word;
    final_block <= fin;
    block_bytes <= nbytes;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Hold the input off until every predicted digest beat has left
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_params(input logic [5:0] out_sz, input logic [5:0] key_sz);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DIGEST_LEN;
    cfg_data  <= out_sz;
    @(posedge clk);
    cfg_index <= CFG_KEY_SIZE;
    cfg_data  <= key_sz;
    @(posedge clk);
    cfg_write <= 1'b0;
    key_now = key_sz;
  endtask

  // Whole blocks of random words; a keyed hash gets a zero-padded key block first
  task automatic send_message(input bit with_start, input int blocks, input bit fin_last,
                              input bit keyed);
    int          b;
    int          w;
    int          sel;
    logic [31:0] word;
    logic        fin;
    logic [6:0]  nbytes;
    if (with_start) begin
      send_beat(ACT_START, $urandom(), 1'($urandom_range(1)), 7'($urandom_range(127)));
    end
    for (b = 0; b < blocks; b++) begin
      for (w = 0; w < 16; w++) begin
        word   = $urandom();
        fin    = 1'($urandom_range(1));
        nbytes = 7'($urandom_range(127));
        if (keyed && b == 0 && w >= 8) begin
          word = '0;
        end
        if (w == 15) begin
          fin = fin_last && (b == blocks - 1);
          sel = $urandom_range(9);
          if (fin) begin
            if (sel < 6) begin
              nbytes = 7'($urandom_range(64));
            end else if (sel < 8) begin
              nbytes = 7'd64;
            end
          end else if (sel < 8) begin
            nbytes = 7'd64;
          end
        end
        send_beat(ACT_WORD, word, fin, nbytes);
      end
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("blake2s_compression_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int          i;
    int          kind;
    int          nblk;
    logic [31:0] word;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: start with its ignored fields at their extremes, then one final
    // block of extreme words whose byte count saturates
    send_beat(ACT_START, '1, 1'b1, 7'h7f);
    for (i = 0; i < 16; i++) begin
      if (i == 0) begin
        word = '0;
      end else if (i == 1) begin
        word = '1;
      end else if (i % 2 == 0) begin
        word = 32'haaaa_aaaa;
      end else begin
        word = 32'h5555_5555;
      end
      send_beat(ACT_WORD, word, 1'b1, (i == 15) ? 7'h7f : 7'h00);
    end

    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (p == RANDOM_CFG) begin
          set_params(6'($urandom_range(32, 1)), 6'($urandom_range(32)));
        end else begin
          set_params(OUT_SETS[p], KEY_SETS[p]);
        end
      end
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];

      while (items_sent < (p + 1) * ITEMS_PER_PHASE) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          // well-formed hash, mostly a single block
          nblk = ($urandom_range(9) < 7) ? 1 : $urandom_range(3, 2);
          send_message(1'b1, nblk, 1'b1, key_now != 6'd0);
        end else if (kind < 80) begin
          // one more block on the current chain, no new start
          send_message(1'b0, 1, 1'($urandom_range(1)), 1'b0);
        end else if (kind < 92) begin
          // abandoned hash: start and a partial block
          send_beat(ACT_START, $urandom(), 1'($urandom_range(1)), 7'($urandom_range(127)));
          repeat ($urandom_range(15, 1)) begin
            send_beat(ACT_WORD, $urandom(), 1'($urandom_range(1)),
                      7'($urandom_range(127)));
          end
        end else begin
          send_beat(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)),
                    7'($urandom_range(127)));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("blake2s_compression_unit: match");
    end else begin
      $display("blake2s_compression_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== blake2s_compression_unit.f =====
+incdir+rtl
rtl/b2s_pkg.sv
rtl/b2s_g_half.sv
rtl/b2s_msg_buf.sv
rtl/blake2s_compression_unit.sv
rtl/b2s_checker.sv
dv/blake2s_digest_checker.sv
dv/blake2s_compression_unit_tb.sv
